// ----- src/multi_index_linearizer_macros.svh -----
// Assertion macros shared by the linearizer RTL.
`ifndef MULTI_INDEX_LINEARIZER_MACROS_SVH
`define MULTI_INDEX_LINEARIZER_MACROS_SVH
`ifndef SYNTH
`define MIL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define MIL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define MIL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MIL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- src/mil_pkg.sv -----
// Types, constants and the divide step shared by the linearizer modules.
package mil_pkg;

   localparam int MAX_DIMS     = 4;
   localparam int DIM_WIDTH    = 15;
   localparam int LIN_WIDTH    = 60;
   localparam int CNT_WIDTH    = 3;
   localparam int SEL_WIDTH    = 2;
   localparam int DIV_STEP     = 4;
   localparam int DIV_STAGES   = LIN_WIDTH / DIV_STEP;
   localparam int NDIV         = MAX_DIMS - 1;
   localparam int FRONT_STAGES = 4;
   localparam int H_SPLIT      = 23;
   localparam int ADDR_WIDTH   = 5;
   localparam int DATA_WIDTH   = 32;

   localparam logic [1:0] KIND_TO_LINEAR = 2'd0;
   localparam logic [1:0] KIND_TO_COORDS = 2'd1;
   localparam logic [1:0] KIND_ONE_COORD = 2'd2;
   localparam logic [1:0] KIND_TOTAL     = 2'd3;

   localparam logic [2:0] REG_NUM_DIMS   = 3'd0;
   localparam logic [2:0] REG_DIM_SIZE_0 = 3'd1;
   localparam logic [2:0] REG_DIM_SIZE_1 = 3'd2;
   localparam logic [2:0] REG_DIM_SIZE_2 = 3'd3;
   localparam logic [2:0] REG_DIM_SIZE_3 = 3'd4;

   typedef logic [DIM_WIDTH-1:0] dim_type;
   typedef logic [LIN_WIDTH-1:0] lin_type;
   typedef logic [1:0]           kind_type;

   typedef struct packed {
      logic [CNT_WIDTH-1:0]     dims;
      dim_type [MAX_DIMS-1:0]   radix;
   } cfg_type;

   typedef struct packed {
      kind_type                 kind;
      logic [SEL_WIDTH-1:0]     sel;
      logic [CNT_WIDTH-1:0]     dims;
      logic                     coord_bad;
      logic                     lin_bad;
      lin_type                  acc;
      lin_type                  total;
      dim_type [MAX_DIMS-1:0]   coord;
   } side_type;

   typedef struct packed {
      dim_type rem;
      lin_type num;
   } div_type;

   // DIV_STEP restoring divide steps; quotient bits shift into num
   function automatic div_type div_step(div_type s, dim_type d);
      logic [DIM_WIDTH:0] t;
      div_type            r;
      r = s;
      for (int i = 0; i < DIV_STEP; i++) begin
         t = {r.rem, r.num[LIN_WIDTH-1]};
         if (t >= {1'b0, d}) begin
            t     = t - {1'b0, d};
            r.num = {r.num[LIN_WIDTH-2:0], 1'b1};
         end else begin
            r.num = {r.num[LIN_WIDTH-2:0], 1'b0};
         end
         r.rem = t[DIM_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

// ----- src/mil_csr.sv -----
// Configuration registers on the APB-style port, plus the effective shape.
module mil_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mil_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [mil_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [mil_pkg::DATA_WIDTH-1:0] prdata,
   output logic                          pready,
   output mil_pkg::cfg_type              cfg
);
   import mil_pkg::*;

   logic [CNT_WIDTH-1:0]   num_dims_ff, num_dims_in;
   dim_type [MAX_DIMS-1:0] size_ff, size_in;
   logic [2:0]             idx;
   logic                   wr;
   logic [CNT_WIDTH-1:0]   dims;

   assign idx    = paddr[4:2];
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      num_dims_in = num_dims_ff;
      size_in     = size_ff;
      if (wr) begin
         case (idx)
            REG_NUM_DIMS:   num_dims_in = pwdata[CNT_WIDTH-1:0];
            REG_DIM_SIZE_0: size_in[0]  = pwdata[DIM_WIDTH-1:0];
            REG_DIM_SIZE_1: size_in[1]  = pwdata[DIM_WIDTH-1:0];
            REG_DIM_SIZE_2: size_in[2]  = pwdata[DIM_WIDTH-1:0];
            REG_DIM_SIZE_3: size_in[3]  = pwdata[DIM_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= CNT_WIDTH'(1);
         size_ff     <= {MAX_DIMS{DIM_WIDTH'(1)}};
      end else begin
         num_dims_ff <= num_dims_in;
         size_ff     <= size_in;
      end
   end

   always_comb begin
      case (idx)
         REG_NUM_DIMS:   prdata = DATA_WIDTH'(num_dims_ff);
         REG_DIM_SIZE_0: prdata = DATA_WIDTH'(size_ff[0]);
         REG_DIM_SIZE_1: prdata = DATA_WIDTH'(size_ff[1]);
         REG_DIM_SIZE_2: prdata = DATA_WIDTH'(size_ff[2]);
         REG_DIM_SIZE_3: prdata = DATA_WIDTH'(size_ff[3]);
         default:        prdata = '0;
      endcase
   end

   // zero count acts as one, large count clamps
   always_comb begin
      if (num_dims_ff == '0)
         dims = CNT_WIDTH'(1);
      else if (num_dims_ff > CNT_WIDTH'(MAX_DIMS))
         dims = CNT_WIDTH'(MAX_DIMS);
      else
         dims = num_dims_ff;
   end

   // unused dims get radix 1 so products and divides pass through
   always_comb begin
      cfg.dims = dims;
      for (int k = 0; k < MAX_DIMS; k++) begin
         if (dims > CNT_WIDTH'(k))
            cfg.radix[k] = (size_ff[k] == '0) ? DIM_WIDTH'(1) : size_ff[k];
         else
            cfg.radix[k] = DIM_WIDTH'(1);
      end
   end

endmodule

// ----- src/mil_front.sv -----
// Front stages: coordinate checks, Horner accumulate, total count, range check.
module mil_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  mil_pkg::kind_type                      kind,
   input  mil_pkg::dim_type [mil_pkg::MAX_DIMS-1:0] coord_in,
   input  mil_pkg::lin_type                       linear_in,
   input  logic [mil_pkg::SEL_WIDTH-1:0]          dim_select,
   input  mil_pkg::cfg_type                       cfg,
   output logic                                   out_valid,
   output mil_pkg::side_type                      out_side,
   output mil_pkg::lin_type                       out_lin
);
   import mil_pkg::*;

   dim_type [MAX_DIMS-1:0] cm1;
   logic                   bad;

   logic                     s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   side_type                 s1_side_ff, s2_side_ff, s3_side_ff, s4_side_ff;
   side_type                 s1_side_in, s2_side_in, s3_side_in, s4_side_in;
   lin_type                  s1_lin_ff, s2_lin_ff, s3_lin_ff, s4_lin_ff;
   dim_type                  s1_c0_ff, s2_c0_ff, s3_c0_ff;
   dim_type                  s1_c1_ff;
   logic [2*DIM_WIDTH-1:0]   s1_h2_ff, s1_p01_ff, s1_p23_ff;
   logic [3*DIM_WIDTH-1:0]   s2_h1_ff;
   logic [DIM_WIDTH+LIN_WIDTH-H_SPLIT-1:0] s3_hi_ff;
   logic [DIM_WIDTH+H_SPLIT-1:0]           s3_lo_ff;
   logic [2*DIM_WIDTH-1:0]   h2_in;
   logic [3*DIM_WIDTH-1:0]   h1_in;
   lin_type                  acc_in;

   always_comb begin
      bad = 1'b0;
      for (int k = 0; k < MAX_DIMS; k++) begin
         if (cfg.dims > CNT_WIDTH'(k)) begin
            cm1[k] = coord_in[k] - DIM_WIDTH'(1);
            if (coord_in[k] == '0 || coord_in[k] > cfg.radix[k]) bad = 1'b1;
         end else begin
            cm1[k] = '0;
         end
      end
   end

   always_comb begin
      s1_side_in           = '0;
      s1_side_in.kind      = kind;
      s1_side_in.sel       = dim_select;
      s1_side_in.dims      = cfg.dims;
      s1_side_in.coord_bad = bad;
      h2_in = (2*DIM_WIDTH)'(cfg.radix[2] * cm1[3]) + (2*DIM_WIDTH)'(cm1[2]);
   end

   always_comb begin
      s2_side_in       = s1_side_ff;
      s2_side_in.total = LIN_WIDTH'(s1_p01_ff * s1_p23_ff);
      h1_in = (3*DIM_WIDTH)'(cfg.radix[1] * s1_h2_ff) + (3*DIM_WIDTH)'(s1_c1_ff);
   end

   always_comb begin
      s3_side_in         = s2_side_ff;
      s3_side_in.lin_bad = (s2_lin_ff >= s2_side_ff.total);
   end

   always_comb begin
      acc_in = LIN_WIDTH'({s3_hi_ff, H_SPLIT'(0)}) + LIN_WIDTH'(s3_lo_ff)
             + LIN_WIDTH'(s3_c0_ff);
      s4_side_in     = s3_side_ff;
      s4_side_in.acc = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_side_ff <= s1_side_in;
      s1_lin_ff  <= linear_in;
      s1_c0_ff   <= cm1[0];
      s1_c1_ff   <= cm1[1];
      s1_h2_ff   <= h2_in;
      s1_p01_ff  <= (2*DIM_WIDTH)'(cfg.radix[0] * cfg.radix[1]);
      s1_p23_ff  <= (2*DIM_WIDTH)'(cfg.radix[2] * cfg.radix[3]);

      s2_side_ff <= s2_side_in;
      s2_lin_ff  <= s1_lin_ff;
      s2_c0_ff   <= s1_c0_ff;
      s2_h1_ff   <= h1_in;

      // r0 * h1 split in two partial products
      s3_side_ff <= s3_side_in;
      s3_lin_ff  <= s2_lin_ff;
      s3_c0_ff   <= s2_c0_ff;
      s3_hi_ff   <= (DIM_WIDTH+LIN_WIDTH-H_SPLIT)'(
                       cfg.radix[0] * s2_h1_ff[3*DIM_WIDTH-1:H_SPLIT]);
      s3_lo_ff   <= (DIM_WIDTH+H_SPLIT)'(cfg.radix[0] * s2_h1_ff[H_SPLIT-1:0]);

      s4_side_ff <= s4_side_in;
      s4_lin_ff  <= s3_lin_ff;
   end

   assign out_valid = s4_vld_ff;
   assign out_side  = s4_side_ff;
   assign out_lin   = s4_lin_ff;

endmodule

// ----- src/mil_div.sv -----
// Pipelined restoring divider: wide index by one radix, DIV_STEP quotient bits per stage.
module mil_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  mil_pkg::lin_type   dividend,
   input  mil_pkg::dim_type   divisor,
   input  mil_pkg::side_type  in_side,
   output logic               out_valid,
   output mil_pkg::lin_type   quotient,
   output mil_pkg::dim_type   remainder,
   output mil_pkg::side_type  out_side
);
   import mil_pkg::*;

   logic     vld_ff  [DIV_STAGES];
   div_type  st_ff   [DIV_STAGES];
   side_type side_ff [DIV_STAGES];
   div_type  st_in   [DIV_STAGES];

   genvar s;
   generate
      for (s = 0; s < DIV_STAGES; s++) begin : g_stage
         if (s == 0) begin : g_first
            always_comb st_in[s] = div_step('{rem: '0, num: dividend}, divisor);
            always_ff @(posedge clock) begin
               if (reset) vld_ff[s] <= 1'b0;
               else       vld_ff[s] <= in_valid;
            end
            always_ff @(posedge clock) side_ff[s] <= in_side;
         end else begin : g_next
            always_comb st_in[s] = div_step(st_ff[s-1], divisor);
            always_ff @(posedge clock) begin
               if (reset) vld_ff[s] <= 1'b0;
               else       vld_ff[s] <= vld_ff[s-1];
            end
            always_ff @(posedge clock) side_ff[s] <= side_ff[s-1];
         end
         always_ff @(posedge clock) st_ff[s] <= st_in[s];
      end
   endgenerate

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign quotient  = st_ff[DIV_STAGES-1].num;
   assign remainder = st_ff[DIV_STAGES-1].rem;
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

// ----- src/multi_index_linearizer.sv -----
// Top level: column-major index linearizer, coordinates <-> linear index.
//
// channel   direction  handshake                      payload
// req       in         start && !busy                 req_kind .. req_dim_select
// rsp       out        rsp_valid, one cycle, no stall rsp_linear_out .. rsp_out_of_range
// csr       in/out     psel && penable && pwrite      paddr, pwdata, prdata
//
// One item per cycle through 50 register stages: 4 front stages, three 15-stage
// dividers (4 quotient bits a stage) and the output register. The first stage
// loads at the accept edge, and rsp_valid is the output register's valid bit.
// busy is high in reset and the cycle after it only, so the pipe never stalls.
// Synchronous reset clears the valid bits and the registers to shape 1x1x1x1.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "multi_index_linearizer_macros.svh"
module multi_index_linearizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_kind,
   input  logic [mil_pkg::DIM_WIDTH-1:0]  req_coord_in_0,
   input  logic [mil_pkg::DIM_WIDTH-1:0]  req_coord_in_1,
   input  logic [mil_pkg::DIM_WIDTH-1:0]  req_coord_in_2,
   input  logic [mil_pkg::DIM_WIDTH-1:0]  req_coord_in_3,
   input  logic [mil_pkg::LIN_WIDTH-1:0]  req_linear_in,
   input  logic [1:0]                     req_dim_select,
   output logic                           rsp_valid,
   output logic [mil_pkg::LIN_WIDTH-1:0]  rsp_linear_out,
   output logic [mil_pkg::DIM_WIDTH-1:0]  rsp_coord_out_0,
   output logic [mil_pkg::DIM_WIDTH-1:0]  rsp_coord_out_1,
   output logic [mil_pkg::DIM_WIDTH-1:0]  rsp_coord_out_2,
   output logic [mil_pkg::DIM_WIDTH-1:0]  rsp_coord_out_3,
   output logic                           rsp_out_of_range,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mil_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [mil_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [mil_pkg::DATA_WIDTH-1:0] prdata,
   output logic                           pready
);
   import mil_pkg::*;

   localparam int PIPE_LAT = FRONT_STAGES + NDIV * DIV_STAGES + 1;

   cfg_type                cfg;
   logic                   busy_ff;
   logic                   accept;
   dim_type [MAX_DIMS-1:0] coord_in;

   logic     front_vld;
   side_type front_side;
   lin_type  front_lin;

   // divider chain: divider k's remainder is coordinate k (0-based)
   logic     dv_in_vld  [NDIV];
   lin_type  dv_in_num  [NDIV];
   side_type dv_in_side [NDIV];
   logic     dv_vld     [NDIV];
   lin_type  dv_quo     [NDIV];
   dim_type  dv_rem     [NDIV];
   side_type dv_side    [NDIV];

   side_type fin_side;
   logic     sel_bad;

   logic                   rsp_valid_ff;
   lin_type                rsp_lin_ff, rsp_lin_in;
   dim_type [MAX_DIMS-1:0] rsp_coord_ff, rsp_coord_in;
   logic                   rsp_oor_ff, rsp_oor_in;

   // hold off items for the cycle right after reset
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b1;
      else       busy_ff <= 1'b0;
   end
   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   assign coord_in = {req_coord_in_3, req_coord_in_2, req_coord_in_1, req_coord_in_0};

   mil_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mil_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .kind       (req_kind),
      .coord_in   (coord_in),
      .linear_in  (req_linear_in),
      .dim_select (req_dim_select),
      .cfg        (cfg),
      .out_valid  (front_vld),
      .out_side   (front_side),
      .out_lin    (front_lin)
   );

   genvar k;
   generate
      for (k = 0; k < NDIV; k++) begin : g_div
         if (k == 0) begin : g_first
            always_comb begin
               dv_in_vld[k]  = front_vld;
               dv_in_num[k]  = front_lin;
               dv_in_side[k] = front_side;
            end
         end else begin : g_next
            always_comb begin
               dv_in_vld[k]  = dv_vld[k-1];
               dv_in_num[k]  = dv_quo[k-1];
               dv_in_side[k] = dv_side[k-1];
               dv_in_side[k].coord[k-1] = dv_rem[k-1];
            end
         end
         mil_div u_div (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (dv_in_vld[k]),
            .dividend  (dv_in_num[k]),
            .divisor   (cfg.radix[k]),
            .in_side   (dv_in_side[k]),
            .out_valid (dv_vld[k]),
            .quotient  (dv_quo[k]),
            .remainder (dv_rem[k]),
            .out_side  (dv_side[k])
         );
      end
   endgenerate

   // last remainder, and the slowest coordinate is what is left over
   always_comb begin
      fin_side = dv_side[NDIV-1];
      fin_side.coord[NDIV-1]   = dv_rem[NDIV-1];
      fin_side.coord[MAX_DIMS-1] = dv_quo[NDIV-1][DIM_WIDTH-1:0];
   end

   assign sel_bad = (CNT_WIDTH'(fin_side.sel) >= fin_side.dims);

   // result select by kind; a flagged item reads all zero
   always_comb begin
      rsp_lin_in   = '0;
      rsp_coord_in = '0;
      rsp_oor_in   = 1'b0;
      case (fin_side.kind)
         KIND_TO_LINEAR: begin
            rsp_oor_in = fin_side.coord_bad;
            if (!fin_side.coord_bad) rsp_lin_in = fin_side.acc;
         end
         KIND_TO_COORDS: begin
            rsp_oor_in = fin_side.lin_bad;
            for (int d = 0; d < MAX_DIMS; d++) begin
               if (!fin_side.lin_bad && fin_side.dims > CNT_WIDTH'(d))
                  rsp_coord_in[d] = fin_side.coord[d] + DIM_WIDTH'(1);
            end
         end
         KIND_ONE_COORD: begin
            rsp_oor_in = fin_side.lin_bad | sel_bad;
            if (!fin_side.lin_bad && !sel_bad)
               rsp_coord_in[0] = fin_side.coord[fin_side.sel] + DIM_WIDTH'(1);
         end
         KIND_TOTAL: begin
            rsp_lin_in = fin_side.total;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= dv_vld[NDIV-1];
   end

   always_ff @(posedge clock) begin
      rsp_lin_ff   <= rsp_lin_in;
      rsp_coord_ff <= rsp_coord_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_linear_out   = rsp_lin_ff;
   assign rsp_coord_out_0  = rsp_coord_ff[0];
   assign rsp_coord_out_1  = rsp_coord_ff[1];
   assign rsp_coord_out_2  = rsp_coord_ff[2];
   assign rsp_coord_out_3  = rsp_coord_ff[3];
   assign rsp_out_of_range = rsp_oor_ff;

   `MIL_ASSERT_IMP(a_rsp_has_item, clock, reset, rsp_valid, $past(accept, PIPE_LAT))
   `MIL_ASSERT_IMP(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range, rsp_linear_out == '0 && rsp_coord_out_1 == '0)
   `MIL_ASSERT_IMP(a_coords_no_lin, clock, reset, rsp_valid && rsp_coord_out_1 != '0, rsp_linear_out == '0 && !rsp_out_of_range)
   `MIL_ASSERT_NXT(a_busy_once, clock, reset, !reset, !busy)

endmodule
